[design/tccw_pkg.sv]
// Shared package for the text console character writer.
// Holds field widths, request and character codes, and the controller/datapath structs.
// No dependencies.
package tccw_pkg;

   // Default geometry
   localparam int COLUMNS_DEF  = 80;
   localparam int ROWS_DEF     = 25;
   localparam int TAB_STOP_DEF = 4;

   // Port field widths
   localparam int REQ_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int ROW_IN_W  = 5;
   localparam int COL_IN_W  = 7;
   localparam int CELL_W    = 16;
   localparam int POS_OUT_W = 11;

   // Request kinds
   localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SET   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

   // Control characters
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   // Attribute of blank cells after reset
   localparam logic [CHAR_W-1:0] FILL_COLOR_RESET = 8'd7;

   // Character classes
   localparam logic [2:0] CC_PRINT     = 3'd0;
   localparam logic [2:0] CC_NEWLINE   = 3'd1;
   localparam logic [2:0] CC_TAB       = 3'd2;
   localparam logic [2:0] CC_RETURN    = 3'd3;
   localparam logic [2:0] CC_BACKSPACE = 3'd4;

   // Column operations
   localparam logic [1:0] COL_KEEP = 2'd0;
   localparam logic [1:0] COL_INC  = 2'd1;
   localparam logic [1:0] COL_ZERO = 2'd2;
   localparam logic [1:0] COL_DEC  = 2'd3;

   // Commands from controller to datapath
   typedef struct packed {
      logic       latch;         // capture request fields
      logic       wr_cell;       // write one cell at the cursor
      logic       wr_space;      // write a space instead of the request character
      logic       wr_prev;       // write one column left of the cursor
      logic [1:0] col_op;        // column update
      logic       row_inc;       // advance row
      logic       row_zero;      // home row
      logic       cur_set;       // load saturated target position
      logic       rd_cell;       // read cell at saturated target
      logic       sweep_start;   // arm a whole-store sweep
      logic       sweep_scroll;  // sweep copies rows up instead of filling
      logic       sweep_run;     // advance the sweep one cell
      logic       mark_scroll;   // flag this transaction as scrolled
      logic       rsp_load;      // load the result registers
   } tccw_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [REQ_W-1:0] req_kind;
      logic [2:0]       char_kind;
      logic             col_zero;
      logic             col_last;
      logic             row_last;
      logic             next_tab_stop;
      logic             sweep_last;
   } tccw_stat_type;

endpackage

[design/tccw_dp.sv]
// Datapath of the text console character writer: screen store, cursor, sweep and result registers.
// Depends on tccw_pkg; driven by tccw_ctrl through tccw_cmd_type.
module tccw_dp #(
   parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
   parameter int ROWS     = tccw_pkg::ROWS_DEF,
   parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tccw_pkg::tccw_cmd_type           cmd,
   output tccw_pkg::tccw_stat_type          stat,
   input  logic [tccw_pkg::REQ_W-1:0]       req_type,
   input  logic [tccw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tccw_pkg::CHAR_W-1:0]      req_char_color,
   input  logic [tccw_pkg::ROW_IN_W-1:0]    req_target_row,
   input  logic [tccw_pkg::COL_IN_W-1:0]    req_target_col,
   input  logic                             csr_we,
   input  logic [tccw_pkg::CHAR_W-1:0]      csr_wdata,
   output logic                             rsp_strobe,
   output logic [tccw_pkg::CELL_W-1:0]      rsp_cell_data,
   output logic [tccw_pkg::ROW_IN_W-1:0]    rsp_cursor_row,
   output logic [tccw_pkg::COL_IN_W-1:0]    rsp_cursor_col,
   output logic [tccw_pkg::POS_OUT_W-1:0]   rsp_cursor_pos,
   output logic                             rsp_scrolled
);
   import tccw_pkg::*;

   localparam int CW         = $clog2(COLUMNS);
   localparam int RW         = $clog2(ROWS);
   localparam int CELLS      = ROWS * COLUMNS;
   localparam int AW         = $clog2(CELLS);
   localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

   localparam logic [CW-1:0] COL_MAX   = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] ROW_MAX   = RW'(ROWS - 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
   localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);

   // Latched request
   logic [REQ_W-1:0]    req_type_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic [CHAR_W-1:0]   color_ff;
   logic [ROW_IN_W-1:0] trow_ff;
   logic [COL_IN_W-1:0] tcol_ff;

   // Cursor and configuration
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [CHAR_W-1:0] fill_color_ff;
   logic              scroll_ff;

   // Sweep engine
   logic [AW-1:0]     sweep_addr_ff;
   logic              sweep_scroll_ff;
   logic [CHAR_W-1:0] sweep_color_ff;
   logic              sweep_copy;
   logic              pend_ff;
   logic [AW-1:0]     pend_addr_ff;
   logic              pend_copy_ff;

   // Screen store
   logic [CELL_W-1:0] cells_ff [CELLS];
   logic [CELL_W-1:0] mem_rd_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [CELL_W-1:0] mem_wdata;

   // Address and decode helpers
   logic [RW-1:0]     sat_row;
   logic [CW-1:0]     sat_col;
   logic [AW-1:0]     cur_addr, tgt_addr, cell_addr;
   logic [CW-1:0]     col_next;
   logic [2:0]        char_kind;
   logic [COLUMNS-1:0] tab_mask;

   // Result registers
   logic                 rsp_strobe_ff;
   logic [CELL_W-1:0]    rsp_cell_ff;
   logic [ROW_IN_W-1:0]  rsp_row_ff;
   logic [COL_IN_W-1:0]  rsp_col_ff;
   logic [POS_OUT_W-1:0] rsp_pos_ff;
   logic                 rsp_scrolled_ff;

   // Tab stop table: bit set where the column is a multiple of the tab stop
   for (genvar i = 0; i < COLUMNS; i++) begin : g_tab
      localparam bit IS_STOP = ((i % TAB_STOP) == 0);
      assign tab_mask[i] = IS_STOP;
   end

   // Saturated target and linear addresses
   always_comb begin
      sat_row   = (int'(trow_ff) > ROWS - 1) ? ROW_MAX : RW'(trow_ff);
      sat_col   = (int'(tcol_ff) > COLUMNS - 1) ? COL_MAX : CW'(tcol_ff);
      cur_addr  = AW'(row_ff) * COL_STEP + AW'(col_ff);
      tgt_addr  = AW'(sat_row) * COL_STEP + AW'(sat_col);
      cell_addr = cmd.wr_prev ? (cur_addr - AW'(1)) : cur_addr;
      col_next  = col_ff + CW'(1);
   end

   // Character class
   always_comb begin
      unique case (char_ff)
         CH_NEWLINE:   char_kind = CC_NEWLINE;
         CH_TAB:       char_kind = CC_TAB;
         CH_RETURN:    char_kind = CC_RETURN;
         CH_BACKSPACE: char_kind = CC_BACKSPACE;
         default:      char_kind = CC_PRINT;
      endcase
   end

   // Status to controller
   always_comb begin
      stat.req_kind      = req_type_ff;
      stat.char_kind     = char_kind;
      stat.col_zero      = (col_ff == '0);
      stat.col_last      = (col_ff == COL_MAX);
      stat.row_last      = (row_ff == ROW_MAX);
      stat.next_tab_stop = (col_ff == COL_MAX) ? 1'b1 : tab_mask[col_next];
      stat.sweep_last    = (sweep_addr_ff == LAST_ADDR);
   end

   // Request latch
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_type_ff <= req_type;
         char_ff     <= req_char_code;
         color_ff    <= req_char_color;
         trow_ff     <= req_target_row;
         tcol_ff     <= req_target_col;
      end
   end

   // Next cursor position
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.cur_set) begin
         row_in = sat_row;
         col_in = sat_col;
      end else begin
         case (cmd.col_op)
            COL_INC:  col_in = col_next;
            COL_ZERO: col_in = '0;
            COL_DEC:  col_in = col_ff - CW'(1);
            default:  col_in = col_ff;
         endcase
         if (cmd.row_zero) begin
            row_in = '0;
         end else if (cmd.row_inc) begin
            row_in = row_ff + RW'(1);
         end
      end
   end

   // Cursor, colour register and scroll flag
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         fill_color_ff <= FILL_COLOR_RESET;
         scroll_ff     <= 1'b0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         if (csr_we) begin
            fill_color_ff <= csr_wdata;
         end
         if (cmd.latch) begin
            scroll_ff <= 1'b0;
         end else if (cmd.mark_scroll) begin
            scroll_ff <= 1'b1;
         end
      end
   end

   // Sweep control: reset starts a fill in the reset attribute
   assign sweep_copy = sweep_scroll_ff && (int'(sweep_addr_ff) < COPY_CELLS);

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_addr_ff   <= '0;
         sweep_scroll_ff <= 1'b0;
         sweep_color_ff  <= FILL_COLOR_RESET;
         pend_ff         <= 1'b0;
      end else begin
         if (cmd.sweep_start) begin
            sweep_addr_ff   <= '0;
            sweep_scroll_ff <= cmd.sweep_scroll;
            sweep_color_ff  <= fill_color_ff;
         end else if (cmd.sweep_run) begin
            sweep_addr_ff <= sweep_addr_ff + AW'(1);
         end
         pend_ff <= cmd.sweep_run;
      end
   end

   // Sweep write stage follows the read in the next cycle
   always_ff @(posedge clock) begin
      pend_addr_ff <= sweep_addr_ff;
      pend_copy_ff <= sweep_copy;
   end

   // Store port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cell_addr;
      mem_wdata = {color_ff, (cmd.wr_space ? CH_SPACE : char_ff)};
      if (pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pend_addr_ff;
         mem_wdata = pend_copy_ff ? mem_rd_ff : {sweep_color_ff, CH_SPACE};
      end else if (cmd.wr_cell) begin
         mem_we = 1'b1;
      end
      if (cmd.sweep_run) begin
         mem_re    = sweep_copy;
         mem_raddr = sweep_addr_ff + COL_STEP;
      end else begin
         mem_re    = cmd.rd_cell;
         mem_raddr = tgt_addr;
      end
   end

   // Screen store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= cells_ff[mem_raddr];
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_cell_ff     <= (req_type_ff == REQ_READ) ? mem_rd_ff : '0;
         rsp_row_ff      <= ROW_IN_W'(row_ff);
         rsp_col_ff      <= COL_IN_W'(col_ff);
         rsp_pos_ff      <= POS_OUT_W'(cur_addr);
         rsp_scrolled_ff <= scroll_ff;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_cell_data  = rsp_cell_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

endmodule

[design/tccw_ctrl.sv]
// Controller of the text console character writer: sequences requests, tabs and sweeps.
// Depends on tccw_pkg; drives tccw_dp through tccw_cmd_type.
module tccw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  tccw_pkg::tccw_stat_type stat,
   output tccw_pkg::tccw_cmd_type  cmd
);
   import tccw_pkg::*;

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_SWEEP = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff, state_in;

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep_run = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            unique case (stat.req_kind)
               REQ_PUT: begin
                  unique case (stat.char_kind)
                     CC_NEWLINE: begin
                        cmd.col_op = COL_ZERO;
                        if (stat.row_last) begin
                           cmd.mark_scroll  = 1'b1;
                           cmd.sweep_start  = 1'b1;
                           cmd.sweep_scroll = 1'b1;
                           state_in         = S_SWEEP;
                        end else begin
                           cmd.row_inc = 1'b1;
                        end
                     end
                     CC_RETURN: begin
                        cmd.col_op = COL_ZERO;
                     end
                     CC_BACKSPACE: begin
                        if (!stat.col_zero) begin
                           cmd.wr_cell  = 1'b1;
                           cmd.wr_space = 1'b1;
                           cmd.wr_prev  = 1'b1;
                           cmd.col_op   = COL_DEC;
                        end
                     end
                     default: begin
                        // printable or one space of a tab
                        cmd.wr_cell  = 1'b1;
                        cmd.wr_space = (stat.char_kind == CC_TAB);
                        if (stat.col_last) begin
                           cmd.col_op = COL_ZERO;
                           if (stat.row_last) begin
                              cmd.mark_scroll  = 1'b1;
                              cmd.sweep_start  = 1'b1;
                              cmd.sweep_scroll = 1'b1;
                              state_in         = S_SWEEP;
                           end else begin
                              cmd.row_inc = 1'b1;
                           end
                        end else begin
                           cmd.col_op = COL_INC;
                           if ((stat.char_kind == CC_TAB) && !stat.next_tab_stop) begin
                              state_in = S_EXEC;
                           end
                        end
                     end
                  endcase
               end
               REQ_CLEAR: begin
                  cmd.sweep_start = 1'b1;
                  cmd.row_zero    = 1'b1;
                  cmd.col_op      = COL_ZERO;
                  state_in        = S_SWEEP;
               end
               REQ_SET: begin
                  cmd.cur_set = 1'b1;
               end
               default: begin
                  cmd.rd_cell = 1'b1;
               end
            endcase
         end
         S_SWEEP: begin
            cmd.sweep_run = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            cmd.rsp_load = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[design/text_console_char_writer.sv]
// Top level of the text console character writer.
// Depends on tccw_pkg, tccw_ctrl and tccw_dp.
//
// Usage:
//  - Request channel: a transaction is taken at a rising edge with start high and busy
//    low. req_type selects put character, clear screen, set cursor or read cell.
//  - Result channel: each transaction gives one result, shown for exactly one cycle
//    with rsp_strobe high; the receiver cannot stall it.
//  - csr_we/csr_wdata write the fill attribute used by clear and scroll.
// Sequencing (cells = ROWS * COLUMNS, 2000 by default):
//  - Most requests: the execute and result states run, then the strobe is registered;
//    busy drops in the strobe cycle, so a new transaction can be taken in that cycle.
//  - Tab: the execute state repeats for each further space written, up to TAB_STOP - 1.
//  - Clear: a sweep fills all cells, one store write a cycle.
//  - Scroll: a sweep moves each row up through the single store port pair, one cell a
//    cycle, and the bottom row is refilled.
// Reset: the cursor homes and a clearing pass writes blanks to all cells, one a cycle;
// busy stays high for that pass. Register writes are taken throughout.
module text_console_char_writer #(
   parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
   parameter int ROWS     = tccw_pkg::ROWS_DEF,
   parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [tccw_pkg::REQ_W-1:0]       req_type,
   input  logic [tccw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tccw_pkg::CHAR_W-1:0]      req_char_color,
   input  logic [tccw_pkg::ROW_IN_W-1:0]    req_target_row,
   input  logic [tccw_pkg::COL_IN_W-1:0]    req_target_col,
   input  logic                             csr_we,
   input  logic [tccw_pkg::CHAR_W-1:0]      csr_wdata,
   output logic                             rsp_strobe,
   output logic [tccw_pkg::CELL_W-1:0]      rsp_cell_data,
   output logic [tccw_pkg::ROW_IN_W-1:0]    rsp_cursor_row,
   output logic [tccw_pkg::COL_IN_W-1:0]    rsp_cursor_col,
   output logic [tccw_pkg::POS_OUT_W-1:0]   rsp_cursor_pos,
   output logic                             rsp_scrolled
);
   import tccw_pkg::*;

   tccw_cmd_type  cmd;
   tccw_stat_type stat;

   // Sequencer
   tccw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Store, cursor and result path
   tccw_dp #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_char_color (req_char_color),
      .req_target_row (req_target_row),
      .req_target_col (req_target_col),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_scrolled   (rsp_scrolled)
   );

endmodule

[design/tccw_checker.sv]
// Port-level checks for the text console character writer, bound to the top level.
// Depends on tccw_pkg and text_console_char_writer.
module tccw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [tccw_pkg::REQ_W-1:0]       req_type,
   input logic [tccw_pkg::CHAR_W-1:0]      req_char_code,
   input logic [tccw_pkg::CHAR_W-1:0]      req_char_color,
   input logic [tccw_pkg::ROW_IN_W-1:0]    req_target_row,
   input logic [tccw_pkg::COL_IN_W-1:0]    req_target_col,
   input logic                             csr_we,
   input logic [tccw_pkg::CHAR_W-1:0]      csr_wdata,
   input logic                             rsp_strobe,
   input logic [tccw_pkg::CELL_W-1:0]      rsp_cell_data,
   input logic [tccw_pkg::ROW_IN_W-1:0]    rsp_cursor_row,
   input logic [tccw_pkg::COL_IN_W-1:0]    rsp_cursor_col,
   input logic [tccw_pkg::POS_OUT_W-1:0]   rsp_cursor_pos,
   input logic                             rsp_scrolled
);
   import tccw_pkg::*;

   // An accepted transaction keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after an accepted transaction");

   // Results never come in back-to-back cycles
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe high for two cycles");

   // A result appears just as the block goes idle
   a_strobe_on_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe outside the first idle cycle");

   // A scroll always leaves the cursor at the start of a line
   a_scroll_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_scrolled) |-> (rsp_cursor_col == '0))
      else $error("scrolled result with non-zero cursor column");

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (.*);
